FILE: hw/rtl/bcg_pkg.sv
// bcg_pkg: shared widths, codes, beat types and the cordic arctangent table
// for the biquad coefficient generator; depends on nothing
package bcg_pkg;

   localparam int COEF_FRAC_BITS_DEF = 28;
   localparam int CORDIC_STAGES_DEF  = 24;
   localparam int CORDIC_MAX         = 32;

   localparam int RATE_W   = 20;
   localparam int FREQ_W   = 24;
   localparam int QUAL_W   = 24;
   localparam int GAIN_W   = 24;
   localparam int PHASE_W  = 32;
   localparam int PH_STEPS = FREQ_W + PHASE_W;
   localparam int ATAN_W   = 30;
   localparam int CS_W     = 34;
   localparam int Z_W      = 33;
   localparam int OPA_W    = 35;
   localparam int OPB_W    = 26;
   localparam int NUM_W    = 58;
   localparam int MAG_W    = 57;
   localparam int QUO_W    = 34;
   localparam int COEF_W   = 32;

   localparam logic [RATE_W-1:0]       RATE_RESET  = 20'd48000;
   localparam logic signed [CS_W-1:0]  CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [OPA_W-1:0] ONE_Q30     = 35'sd1073741824;
   localparam logic [PHASE_W-1:0]      EIGHTH_TURN = 32'h2000_0000;

   localparam logic [1:0] OP_LOWPASS  = 2'd0;
   localparam logic [1:0] OP_HIGHPASS = 2'd1;
   localparam logic [1:0] OP_BANDPASS = 2'd2;
   localparam logic [1:0] OP_NOTCH    = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_QZERO = 2'd1;
   localparam logic [1:0] ST_ABOVE = 2'd2;
   localparam logic [1:0] ST_SAT   = 2'd3;

   localparam logic signed [COEF_W-1:0] COEF_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [COEF_W-1:0] COEF_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic [1:0]               op;
      logic [FREQ_W-1:0]        corner_freq;
      logic [QUAL_W-1:0]        quality;
      logic signed [GAIN_W-1:0] peak_gain;
   } req_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] coef_b0;
      logic signed [COEF_W-1:0] coef_b1;
      logic signed [COEF_W-1:0] coef_b2;
      logic signed [COEF_W-1:0] coef_a1;
      logic signed [COEF_W-1:0] coef_a2;
      logic [1:0]               status;
   } rsp_type;

   // arctangent of 2^-i in units of 2^-32 turn
   function automatic logic [ATAN_W-1:0] atan_turn(input int unsigned idx);
      logic [ATAN_W-1:0] v;
      case (idx)
         0:  v = 30'd536870912;
         1:  v = 30'd316933406;
         2:  v = 30'd167458907;
         3:  v = 30'd85004756;
         4:  v = 30'd42667331;
         5:  v = 30'd21354465;
         6:  v = 30'd10679838;
         7:  v = 30'd5340245;
         8:  v = 30'd2670163;
         9:  v = 30'd1335087;
         10: v = 30'd667544;
         11: v = 30'd333772;
         12: v = 30'd166886;
         13: v = 30'd83443;
         14: v = 30'd41722;
         15: v = 30'd20861;
         16: v = 30'd10430;
         17: v = 30'd5215;
         18: v = 30'd2608;
         19: v = 30'd1304;
         20: v = 30'd652;
         21: v = 30'd326;
         22: v = 30'd163;
         23: v = 30'd81;
         24: v = 30'd41;
         25: v = 30'd20;
         26: v = 30'd10;
         27: v = 30'd5;
         28: v = 30'd3;
         29: v = 30'd1;
         30: v = 30'd1;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

endpackage

FILE: hw/rtl/bcg_phase_cell.sv
// bcg_phase_cell: one restoring step of the phase division f*2^32 / (16*fs)
// depends on bcg_pkg
module bcg_phase_cell
   import bcg_pkg::*;
#(
   parameter int IDX = 0
) (
   input  logic               clock,
   input  logic               en,
   input  logic [FREQ_W-1:0]  span,
   input  logic [FREQ_W-1:0]  up_rem,
   input  logic [FREQ_W-1:0]  up_freq,
   input  logic [PHASE_W-1:0] up_phase,
   output logic [FREQ_W-1:0]  dn_rem,
   output logic [FREQ_W-1:0]  dn_freq,
   output logic [PHASE_W-1:0] dn_phase
);

   logic [FREQ_W-1:0]  rem_ff, rem_in;
   logic [FREQ_W-1:0]  freq_ff;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic               nbit;
   logic [FREQ_W:0]    trial, diff;
   logic               ge;

   generate
      if (IDX < FREQ_W) begin : g_num
         assign nbit = up_freq[FREQ_W-1-IDX];
      end else begin : g_zero
         assign nbit = 1'b0;
      end
   endgenerate

   assign trial  = {up_rem, nbit};
   assign ge     = trial >= {1'b0, span};
   assign diff   = trial - {1'b0, span};
   assign rem_in = ge ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];

   generate
      if (IDX >= FREQ_W) begin : g_quo
         assign phase_in = {up_phase[PHASE_W-2:0], ge};
      end else begin : g_pass
         assign phase_in = up_phase;
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff   <= rem_in;
         freq_ff  <= up_freq;
         phase_ff <= phase_in;
      end
   end

   assign dn_rem   = rem_ff;
   assign dn_freq  = freq_ff;
   assign dn_phase = phase_ff;

endmodule

FILE: hw/rtl/bcg_cordic_cell.sv
// bcg_cordic_cell: one rotation step of the sin/cos cordic
// depends on bcg_pkg (widths, arctangent table)
module bcg_cordic_cell
   import bcg_pkg::*;
#(
   parameter int IDX = 0
) (
   input  logic                   clock,
   input  logic                   en,
   input  logic signed [CS_W-1:0] up_x,
   input  logic signed [CS_W-1:0] up_y,
   input  logic signed [Z_W-1:0]  up_z,
   input  logic [1:0]             up_quad,
   output logic signed [CS_W-1:0] dn_x,
   output logic signed [CS_W-1:0] dn_y,
   output logic signed [Z_W-1:0]  dn_z,
   output logic [1:0]             dn_quad
);

   localparam logic signed [Z_W-1:0] ANGLE = $signed(Z_W'(atan_turn(IDX)));

   logic signed [CS_W-1:0] x_ff, x_in, y_ff, y_in, dx, dy;
   logic signed [Z_W-1:0]  z_ff, z_in;
   logic [1:0]             quad_ff;

   assign dx = up_y >>> IDX;
   assign dy = up_x >>> IDX;

   always_comb begin
      if (!up_z[Z_W-1]) begin
         x_in = up_x - dx;
         y_in = up_y + dy;
         z_in = up_z - ANGLE;
      end else begin
         x_in = up_x + dx;
         y_in = up_y - dy;
         z_in = up_z + ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         quad_ff <= up_quad;
      end
   end

   assign dn_x    = x_ff;
   assign dn_y    = y_ff;
   assign dn_z    = z_ff;
   assign dn_quad = quad_ff;

endmodule

FILE: hw/rtl/bcg_div_cell.sv
// bcg_div_cell: one restoring step of a coefficient division, one quotient bit
// depends on bcg_pkg
module bcg_div_cell
   import bcg_pkg::*;
#(
   parameter int DEN_W = 72
) (
   input  logic             clock,
   input  logic             en,
   input  logic [DEN_W-1:0] up_rem,
   input  logic [DEN_W-1:0] up_den,
   input  logic [QUO_W-1:0] up_quo,
   output logic [DEN_W-1:0] dn_rem,
   output logic [DEN_W-1:0] dn_den,
   output logic [QUO_W-1:0] dn_quo
);

   logic [DEN_W-1:0] rem_ff, rem_in, den_ff;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [DEN_W:0]   trial, diff;
   logic             ge;

   assign trial  = {up_rem, 1'b0};
   assign ge     = trial >= {1'b0, up_den};
   assign diff   = trial - {1'b0, up_den};
   assign rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
   assign quo_in = {up_quo[QUO_W-2:0], ge};

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         den_ff <= up_den;
         quo_ff <= quo_in;
      end
   end

   assign dn_rem = rem_ff;
   assign dn_den = den_ff;
   assign dn_quo = quo_ff;

endmodule

FILE: hw/rtl/biquad_coefficient_generator_core.sv
// biquad_coefficient_generator_core: top level, phase, cordic and divider chains
// depends on bcg_pkg, bcg_phase_cell, bcg_cordic_cell, bcg_div_cell
//
// Takes one request beat per cycle while no response beat waits and returns one
// coefficient beat per request, in order, through 56 phase division cells, one
// cordic cell per stage, a register each for operand selection, multiplication
// and sign handling, 34 cells of each of the five parallel coefficient dividers
// and the output register. The whole line moves as one; a response beat left
// waiting holds every stage and drops req_ready. sample_rate is written through
// csr_we and is to be changed only while no request is in flight.
module biquad_coefficient_generator_core
   import bcg_pkg::*;
#(
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
   parameter int CORDIC_STAGES  = CORDIC_STAGES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_we,
   input  logic [RATE_W-1:0] csr_wdata
);

   localparam int LANES  = 5;
   localparam int SB_LEN = PH_STEPS + CORDIC_STAGES;
   localparam int TOTAL  = SB_LEN + 3 + QUO_W;
   localparam int DEN_W  = MAG_W + 33 - COEF_FRAC_BITS;
   localparam int PROD_W = OPA_W + OPB_W;

   typedef struct packed {
      logic [1:0]               op;
      logic [QUAL_W-1:0]        qv;
      logic signed [GAIN_W-1:0] g;
      logic                     qzero;
      logic                     above;
   } sb_type;

   typedef struct packed {
      logic neg;
      logic nz;
      logic ovf;
   } lane_type;

   typedef struct packed {
      logic                       qzero;
      logic                       above;
      logic                       dz;
      lane_type [LANES-1:0]       lane;
   } dsb_type;

   // control
   logic              adv;
   logic [TOTAL-1:0]  vld_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff, rsp_data_in;
   logic [RATE_W-1:0] rate_ff;
   logic [RATE_W-1:0] fs_eff;
   logic [FREQ_W-1:0] span;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= RATE_RESET;
      end else if (csr_we) begin
         rate_ff <= csr_wdata;
      end
   end

   assign fs_eff = (rate_ff == '0) ? RATE_W'(1) : rate_ff;
   assign span   = {fs_eff, 4'b0000};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[TOTAL-2:0], req_valid};
         rsp_valid_ff <= vld_ff[TOTAL-1];
      end
   end

   // sideband along phase and cordic cells
   sb_type sb_ff [SB_LEN];
   sb_type sb_head_in;

   assign sb_head_in.op    = req_data.op;
   assign sb_head_in.qv    = req_data.quality;
   assign sb_head_in.g     = req_data.peak_gain;
   assign sb_head_in.qzero = (req_data.quality == '0);
   assign sb_head_in.above = req_data.corner_freq > {1'b0, fs_eff, 3'b000};

   always_ff @(posedge clock) begin
      if (adv) begin
         sb_ff[0] <= sb_head_in;
         for (int k = 1; k < SB_LEN; k++) begin
            sb_ff[k] <= sb_ff[k-1];
         end
      end
   end

   // phase division chain
   logic [FREQ_W-1:0]  ph_rem   [PH_STEPS+1];
   logic [FREQ_W-1:0]  ph_freq  [PH_STEPS+1];
   logic [PHASE_W-1:0] ph_phase [PH_STEPS+1];

   assign ph_rem[0]   = '0;
   assign ph_freq[0]  = req_data.corner_freq;
   assign ph_phase[0] = '0;

   generate
      for (genvar i = 0; i < PH_STEPS; i++) begin : g_ph
         bcg_phase_cell #(.IDX(i)) u_cell (
            .clock    (clock),
            .en       (adv),
            .span     (span),
            .up_rem   (ph_rem[i]),
            .up_freq  (ph_freq[i]),
            .up_phase (ph_phase[i]),
            .dn_rem   (ph_rem[i+1]),
            .dn_freq  (ph_freq[i+1]),
            .dn_phase (ph_phase[i+1])
         );
      end
   endgenerate

   // cordic chain
   logic signed [CS_W-1:0] co_x    [CORDIC_STAGES+1];
   logic signed [CS_W-1:0] co_y    [CORDIC_STAGES+1];
   logic signed [Z_W-1:0]  co_z    [CORDIC_STAGES+1];
   logic [1:0]             co_quad [CORDIC_STAGES+1];
   logic [PHASE_W-1:0]     turn;

   assign turn       = ph_phase[PH_STEPS] + EIGHTH_TURN;
   assign co_x[0]    = CORDIC_GAIN;
   assign co_y[0]    = '0;
   assign co_z[0]    = $signed(Z_W'(turn[PHASE_W-3:0])) - $signed(Z_W'(EIGHTH_TURN));
   assign co_quad[0] = turn[PHASE_W-1:PHASE_W-2];

   generate
      for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_co
         bcg_cordic_cell #(.IDX(i)) u_cell (
            .clock   (clock),
            .en      (adv),
            .up_x    (co_x[i]),
            .up_y    (co_y[i]),
            .up_z    (co_z[i]),
            .up_quad (co_quad[i]),
            .dn_x    (co_x[i+1]),
            .dn_y    (co_y[i+1]),
            .dn_z    (co_z[i+1]),
            .dn_quad (co_quad[i+1])
         );
      end
   endgenerate

   // operand selection
   logic signed [CS_W-1:0]  cos_v, sin_v;
   logic signed [OPA_W-1:0] c_e, s_e, one_m_c, one_p_c, two_c;
   logic signed [OPB_W-1:0] qv_e, tq_e, g_e;
   logic signed [NUM_W-1:0] qsh, ssh;
   logic signed [OPA_W-1:0] a0_ff, a0_in, a1_ff, a1_in, an_ff;
   logic signed [OPB_W-1:0] b0_ff, b0_in, tq_ff;
   logic signed [NUM_W-1:0] d_ff, na2_ff;
   sb_type                  ops_sb_ff;

   always_comb begin
      case (co_quad[CORDIC_STAGES])
         2'd0: begin
            cos_v = co_x[CORDIC_STAGES];
            sin_v = co_y[CORDIC_STAGES];
         end
         2'd1: begin
            cos_v = -co_y[CORDIC_STAGES];
            sin_v = co_x[CORDIC_STAGES];
         end
         2'd2: begin
            cos_v = -co_x[CORDIC_STAGES];
            sin_v = -co_y[CORDIC_STAGES];
         end
         default: begin
            cos_v = co_y[CORDIC_STAGES];
            sin_v = -co_x[CORDIC_STAGES];
         end
      endcase
   end

   assign c_e     = OPA_W'(cos_v);
   assign s_e     = OPA_W'(sin_v);
   assign one_m_c = ONE_Q30 - c_e;
   assign one_p_c = ONE_Q30 + c_e;
   assign two_c   = c_e <<< 1;
   assign qv_e    = $signed(OPB_W'(sb_ff[SB_LEN-1].qv));
   assign tq_e    = $signed({1'b0, sb_ff[SB_LEN-1].qv, 1'b0});
   assign g_e     = OPB_W'(sb_ff[SB_LEN-1].g);
   assign qsh     = $signed(NUM_W'({sb_ff[SB_LEN-1].qv, 31'b0}));
   assign ssh     = NUM_W'(sin_v) <<< 16;

   always_comb begin
      case (sb_ff[SB_LEN-1].op)
         OP_LOWPASS: begin
            a0_in = one_m_c;
            b0_in = qv_e;
            a1_in = one_m_c;
         end
         OP_HIGHPASS: begin
            a0_in = one_p_c;
            b0_in = qv_e;
            a1_in = -one_p_c;
         end
         OP_BANDPASS: begin
            a0_in = s_e;
            b0_in = g_e;
            a1_in = '0;
         end
         default: begin
            a0_in = ONE_Q30;
            b0_in = tq_e;
            a1_in = -two_c;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a0_ff     <= a0_in;
         b0_ff     <= b0_in;
         a1_ff     <= a1_in;
         an_ff     <= -two_c;
         tq_ff     <= tq_e;
         d_ff      <= qsh + ssh;
         na2_ff    <= qsh - ssh;
         ops_sb_ff <= sb_ff[SB_LEN-1];
      end
   end

   // multiplication
   logic signed [PROD_W-1:0] m0, m1, mn;
   logic signed [NUM_W-1:0]  nb0_ff, nb1_ff, na1_ff, md_ff, mna2_ff;
   sb_type                   mul_sb_ff;

   assign m0 = a0_ff * b0_ff;
   assign m1 = a1_ff * tq_ff;
   assign mn = an_ff * tq_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         nb0_ff    <= m0[NUM_W-1:0];
         nb1_ff    <= m1[NUM_W-1:0];
         na1_ff    <= mn[NUM_W-1:0];
         md_ff     <= d_ff;
         mna2_ff   <= na2_ff;
         mul_sb_ff <= ops_sb_ff;
      end
   end

   // signs and magnitudes
   logic signed [NUM_W-1:0] num [LANES];
   logic [NUM_W-1:0]        dabs;
   logic [MAG_W-1:0]        nm_in  [LANES];
   logic [MAG_W-1:0]        pre_nm_ff [LANES];
   logic [DEN_W-1:0]        pre_den_ff [LANES];
   logic [LANES-1:0]        pre_neg_ff, pre_nz_ff;
   logic                    pre_dz_ff, pre_qz_ff, pre_ab_ff;
   logic [NUM_W-1:0]        nabs [LANES];

   assign num[0] = nb0_ff;
   assign num[1] = nb1_ff;
   assign num[2] = (mul_sb_ff.op == OP_BANDPASS) ? -nb0_ff : nb0_ff;
   assign num[3] = na1_ff;
   assign num[4] = mna2_ff;
   assign dabs   = md_ff[NUM_W-1] ? -md_ff : md_ff;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         nabs[l]  = num[l][NUM_W-1] ? -num[l] : num[l];
         nm_in[l] = nabs[l][MAG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < LANES; l++) begin
            pre_nm_ff[l]  <= nm_in[l];
            pre_den_ff[l] <= DEN_W'(dabs[MAG_W-1:0]) << (DEN_W - MAG_W);
            pre_neg_ff[l] <= num[l][NUM_W-1] ^ md_ff[NUM_W-1];
            pre_nz_ff[l]  <= (num[l] == '0);
         end
         pre_dz_ff <= (md_ff == '0);
         pre_qz_ff <= mul_sb_ff.qzero;
         pre_ab_ff <= mul_sb_ff.above;
      end
   end

   // divider sideband
   dsb_type dsb_ff [QUO_W];
   dsb_type dsb_head_in;

   always_comb begin
      dsb_head_in.qzero = pre_qz_ff;
      dsb_head_in.above = pre_ab_ff;
      dsb_head_in.dz    = pre_dz_ff;
      for (int l = 0; l < LANES; l++) begin
         dsb_head_in.lane[l].neg = pre_neg_ff[l];
         dsb_head_in.lane[l].nz  = pre_nz_ff[l];
         dsb_head_in.lane[l].ovf = DEN_W'(pre_nm_ff[l]) >= pre_den_ff[l];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dsb_ff[0] <= dsb_head_in;
         for (int k = 1; k < QUO_W; k++) begin
            dsb_ff[k] <= dsb_ff[k-1];
         end
      end
   end

   // divider chains, one per coefficient
   logic [DEN_W-1:0] dv_rem [LANES][QUO_W+1];
   logic [DEN_W-1:0] dv_den [LANES][QUO_W+1];
   logic [QUO_W-1:0] dv_quo [LANES][QUO_W+1];

   generate
      for (genvar l = 0; l < LANES; l++) begin : g_lane
         assign dv_rem[l][0] = DEN_W'(pre_nm_ff[l]);
         assign dv_den[l][0] = pre_den_ff[l];
         assign dv_quo[l][0] = '0;
         for (genvar k = 0; k < QUO_W; k++) begin : g_step
            bcg_div_cell #(.DEN_W(DEN_W)) u_cell (
               .clock  (clock),
               .en     (adv),
               .up_rem (dv_rem[l][k]),
               .up_den (dv_den[l][k]),
               .up_quo (dv_quo[l][k]),
               .dn_rem (dv_rem[l][k+1]),
               .dn_den (dv_den[l][k+1]),
               .dn_quo (dv_quo[l][k+1])
            );
         end
      end
   endgenerate

   // rounding, saturation and status
   logic [QUO_W:0]           q_inc [LANES];
   logic [QUO_W-1:0]         rnd   [LANES];
   logic [QUO_W-1:0]         lim   [LANES];
   logic [LANES-1:0]         sat;
   logic signed [COEF_W-1:0] coef  [LANES];
   dsb_type                  tail;

   assign tail = dsb_ff[QUO_W-1];

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         q_inc[l] = {1'b0, dv_quo[l][QUO_W]} + (QUO_W+1)'(1);
         rnd[l]   = q_inc[l][QUO_W:1];
         lim[l]   = tail.lane[l].neg ? QUO_W'(34'h0_8000_0000) : QUO_W'(34'h0_7FFF_FFFF);
         sat[l]   = tail.dz || tail.lane[l].ovf || (rnd[l] > lim[l]);
         if (tail.dz && tail.lane[l].nz) begin
            coef[l] = '0;
         end else if (sat[l]) begin
            coef[l] = tail.lane[l].neg ? COEF_MIN : COEF_MAX;
         end else if (tail.lane[l].neg) begin
            coef[l] = -$signed(rnd[l][COEF_W-1:0]);
         end else begin
            coef[l] = $signed(rnd[l][COEF_W-1:0]);
         end
      end
      rsp_data_in.coef_b0 = coef[0];
      rsp_data_in.coef_b1 = coef[1];
      rsp_data_in.coef_b2 = coef[2];
      rsp_data_in.coef_a1 = coef[3];
      rsp_data_in.coef_a2 = coef[4];
      if (tail.qzero) begin
         rsp_data_in.status = ST_QZERO;
      end else if (tail.above) begin
         rsp_data_in.status = ST_ABOVE;
      end else if (sat != '0) begin
         rsp_data_in.status = ST_SAT;
      end else begin
         rsp_data_in.status = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

FILE: hw/rtl/bcg_checker.sv
// bcg_checker: port-level checks on the coefficient generator, bound to the top
// depends on bcg_pkg and biquad_coefficient_generator_core
module bcg_checker
   import bcg_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // request side frozen exactly while a response beat waits
   a_ready_follows_rsp: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("req_ready does not follow the response stall");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("waiting response beat changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response beat right after reset");

   // a saturated flag always comes with a clipped coefficient
   a_sat_clipped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_SAT |->
         rsp_data.coef_b0 == COEF_MAX || rsp_data.coef_b0 == COEF_MIN ||
         rsp_data.coef_b1 == COEF_MAX || rsp_data.coef_b1 == COEF_MIN ||
         rsp_data.coef_b2 == COEF_MAX || rsp_data.coef_b2 == COEF_MIN ||
         rsp_data.coef_a1 == COEF_MAX || rsp_data.coef_a1 == COEF_MIN ||
         rsp_data.coef_a2 == COEF_MAX || rsp_data.coef_a2 == COEF_MIN)
      else $error("saturation status without a clipped coefficient");

endmodule

bind biquad_coefficient_generator_core bcg_checker u_bcg_checker (.*);

FILE: sim/tb.sv
// tb: self-checking bench for biquad_coefficient_generator_core
// needs bcg_pkg and the core; predicts each coefficient beat in-bench and
// checks every response against it under random stalls and rate changes
`timescale 1ns / 100ps

module tb;
   import bcg_pkg::*;

   localparam int    LIMIT_CYCLES = 600000;
   localparam int    DRAIN_CYCLES = 160;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_data;
   logic              csr_we = 1'b0;
   logic [RATE_W-1:0] csr_wdata = '0;

   req_type     pending_reqs[$];
   rsp_type     coef_expected[$];
   logic [RATE_W-1:0] rate_shadow = RATE_RESET;
   int          send_gap = 0;
   int          stall_left = 0;
   bit          send_burst = 0;
   bit          recv_burst = 0;
   int          cycle_count = 0;
   int          errors = 0;
   int          beats_in = 0;
   int          beats_out = 0;
   int          status_seen[4];

   longint atan_tab[32] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1, 1, 0};

   always #6 clock = ~clock;

   biquad_coefficient_generator_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   function automatic logic signed [31:0] rounded_quotient(input longint n, input longint d,
                                                          inout bit sat);
      bit          neg;
      longint unsigned nm, dm, lim, ip, rem, mag;
      neg = (n < 0) != (d < 0);
      nm = n < 0 ? -n : n;
      dm = d < 0 ? -d : d;
      lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      if (dm == 0) begin
         sat = 1;
         if (nm == 0) return 0;
         return neg ? COEF_MIN : COEF_MAX;
      end
      ip = nm / dm;
      rem = nm % dm;
      if (ip > (64'd1 << (32 - COEF_FRAC_BITS_DEF))) begin
         sat = 1;
         return neg ? COEF_MIN : COEF_MAX;
      end
      mag = ip;
      for (int k = 0; k <= COEF_FRAC_BITS_DEF; k++) begin
         rem = rem << 1;
         mag = mag << 1;
         if (rem >= dm) begin
            rem = rem - dm;
            mag = mag | 1;
         end
      end
      mag = (mag + 1) >> 1;
      if (mag > lim) begin
         sat = 1;
         return neg ? COEF_MIN : COEF_MAX;
      end
      return neg ? 32'(-longint'(mag)) : 32'(longint'(mag));
   endfunction

   function automatic rsp_type biquad_coefs(input req_type rq, input logic [RATE_W-1:0] rate);
      rsp_type r;
      longint unsigned fs, span, ph, quarter;
      longint z, x, y, dx, dy, c, s, qv, tq, g, d, nb0, nb1, nb2, na1, na2;
      bit sat;
      fs = rate == 0 ? 1 : rate;
      span = 16 * fs;
      ph = ((longint'(rq.corner_freq) % span) << 32) / span;
      quarter = (ph + 64'h2000_0000) >> 30;
      z = longint'(ph) - longint'(quarter << 30);
      x = 652032874;
      y = 0;
      for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - atan_tab[i];
         end else begin
            x = x + dx; y = y - dy; z = z + atan_tab[i];
         end
      end
      case (quarter[1:0])
         2'd0: begin c = x; s = y; end
         2'd1: begin c = -y; s = x; end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
      qv = longint'(rq.quality);
      tq = 2 * qv;
      g = longint'(rq.peak_gain);
      d = qv * 64'sd2147483648 + s * 65536;
      na1 = -2 * c * tq;
      na2 = qv * 64'sd2147483648 - s * 65536;
      case (rq.op)
         OP_LOWPASS: begin
            nb0 = (64'sd1073741824 - c) * qv; nb1 = (64'sd1073741824 - c) * tq; nb2 = nb0;
         end
         OP_HIGHPASS: begin
            nb0 = (64'sd1073741824 + c) * qv; nb1 = -(64'sd1073741824 + c) * tq; nb2 = nb0;
         end
         OP_BANDPASS: begin
            nb0 = g * s; nb1 = 0; nb2 = -nb0;
         end
         default: begin
            nb0 = 64'sd1073741824 * tq; nb1 = -2 * c * tq; nb2 = nb0;
         end
      endcase
      sat = 0;
      r.coef_b0 = rounded_quotient(nb0, d, sat);
      r.coef_b1 = rounded_quotient(nb1, d, sat);
      r.coef_b2 = rounded_quotient(nb2, d, sat);
      r.coef_a1 = rounded_quotient(na1, d, sat);
      r.coef_a2 = rounded_quotient(na2, d, sat);
      if (rq.quality == 0) r.status = ST_QZERO;
      else if (longint'(rq.corner_freq) > 8 * fs) r.status = ST_ABOVE;
      else if (sat) r.status = ST_SAT;
      else r.status = ST_OK;
      return r;
   endfunction

   function automatic int pick_gap(input bit burst);
      int r;
      r = $urandom_range(0, 99);
      if (burst || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic void compare_field(input string name, input longint exp_v,
                                         input longint act_v);
      if (exp_v != act_v) begin
         $error("%s expected %0d got %0d", name, exp_v, act_v);
         errors++;
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_valid && req_ready) begin
            coef_expected.push_back(biquad_coefs(req_data, rate_shadow));
            beats_in++;
         end
         if (!(req_valid && !req_ready)) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_data <= pending_reqs.pop_front();
               req_valid <= 1'b1;
               if ($urandom_range(0, 99) == 0) send_burst = ~send_burst;
               send_gap <= pick_gap(send_burst);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            beats_out++;
            if (coef_expected.size() == 0) begin
               $error("response beat with nothing expected");
               errors++;
            end else begin
               e = coef_expected.pop_front();
               status_seen[e.status]++;
               compare_field("coef_b0", e.coef_b0, rsp_data.coef_b0);
               compare_field("coef_b1", e.coef_b1, rsp_data.coef_b1);
               compare_field("coef_b2", e.coef_b2, rsp_data.coef_b2);
               compare_field("coef_a1", e.coef_a1, rsp_data.coef_a1);
               compare_field("coef_a2", e.coef_a2, rsp_data.coef_a2);
               compare_field("status", e.status, rsp_data.status);
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            if ($urandom_range(0, 99) == 0) recv_burst = ~recv_burst;
            stall_left <= pick_gap(recv_burst);
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic add_req(input logic [1:0] op, input logic [23:0] f, input logic [23:0] q,
                          input logic [23:0] g);
      req_type rq;
      rq.op = op;
      rq.corner_freq = f;
      rq.quality = q;
      rq.peak_gain = g;
      pending_reqs.push_back(rq);
   endtask

   task automatic wait_idle();
      wait (pending_reqs.size() == 0 && !req_valid && coef_expected.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_rate(input logic [RATE_W-1:0] v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      rate_shadow = v;
   endtask

   task automatic random_reqs(input int n);
      longint unsigned fs;
      logic [23:0] f, q;
      int r;
      fs = rate_shadow == 0 ? 1 : rate_shadow;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 75) f = (8 * fs > 24'hFFFFFF) ? 24'($urandom())
                                               : 24'($urandom_range(0, 32'(8 * fs)));
         else if (r < 85) f = (16 * fs > 24'hFFFFFF) ? 24'($urandom())
                                                     : 24'($urandom_range(0, 32'(16 * fs)));
         else f = 24'($urandom());
         r = $urandom_range(0, 99);
         if (r < 70) q = 24'($urandom_range(24'h2000, 24'h0A0000));
         else if (r < 78) q = 0;
         else if (r < 88) q = 24'($urandom_range(1, 24'h400));
         else q = 24'($urandom());
         add_req(2'($urandom_range(0, 3)), f, q, 24'($urandom()));
      end
   endtask

   initial begin
      logic [RATE_W-1:0] rates[6];
      rates = '{20'd48000, 20'd1, 20'd1048575, 20'd0, 20'd44100, 20'd0};
      rates[5] = RATE_W'($urandom_range(1, 20'hFFFFF));
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < 6; ph++) begin
         set_rate(rates[ph]);
         if (ph == 0) begin
            for (int o = 0; o < 4; o++) begin
               add_req(2'(o), 24'd16000, 24'h00B505, 24'h010000);
               add_req(2'(o), 24'd0, 24'd0, 24'h7FFFFF);
            end
            add_req(OP_BANDPASS, 24'd384000, 24'hFFFFFF, 24'h800000);
            add_req(OP_BANDPASS, 24'd384001, 24'd1, 24'h7FFFFF);
            add_req(OP_LOWPASS, 24'hFFFFFF, 24'h010000, 24'h000000);
            add_req(OP_HIGHPASS, 24'd192000, 24'd1, 24'h000000);
            add_req(OP_NOTCH, 24'd768000, 24'h008000, 24'hFFFFFF);
            add_req(OP_LOWPASS, 24'd576000, 24'h008000, 24'h000000);
            add_req(OP_BANDPASS, 24'd576000, 24'h008000, 24'h800000);
            add_req(OP_HIGHPASS, 24'd1, 24'hFFFFFF, 24'h555555);
            add_req(OP_NOTCH, 24'd383999, 24'h000100, 24'hAAAAAA);
         end
         random_reqs(305);
         wait_idle();
      end
      $display("tb: %0d request beats, %0d response beats over six sample rates",
               beats_in, beats_out);
      $display("tb: status ok %0d, q zero %0d, above nyquist %0d, saturated %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      if (errors == 0 && coef_expected.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/bcg_pkg.sv
hw/rtl/bcg_phase_cell.sv
hw/rtl/bcg_cordic_cell.sv
hw/rtl/bcg_div_cell.sv
hw/rtl/biquad_coefficient_generator_core.sv
hw/rtl/bcg_checker.sv
sim/tb.sv
